// ----- rtl/cobs_rx_pkg.sv -----
// ============================================================================
// COBS receiver package
// Types and constants that the receiver's controller, datapath and checker
// share, and the CRC16-CCITT byte update that the datapath uses.
// ============================================================================
`default_nettype none

package cobs_rx_pkg;

    // Fixed widths of the result fields.
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 6;
    localparam int POS_W    = 6;

    // Byte values with a special meaning on the link.
    localparam logic [7:0] ZERO_BYTE = 8'h00;
    localparam logic [7:0] FF_BYTE   = 8'hFF;
    localparam logic [7:0] ONE_BYTE  = 8'h01;

    // CRC16-CCITT, not reflected, no final inversion.
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        FRAME_GOOD       = 2'd0,
        FRAME_DECODE_ERR = 2'd1,
        FRAME_CRC_ERR    = 2'd2
    } frame_status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;       // input side open for a transaction
        logic proc;         // process the raw byte read last cycle
        logic zero;         // append the implied zero of a finished group
        logic out_init;     // point the payload read at the first payload byte
        logic out_next;     // advance the payload read
        logic load_pay;     // load a payload result into the output register
        logic load_single;  // load an error or empty-payload result
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic close;        // current input byte closes a non-empty frame
        logic dec_stop;     // decode finished or failed
        logic zero_need;    // processed byte ends a group that implies a zero
        logic single;       // frame gives exactly one result
        logic last_idx;     // payload read points at the final payload byte
        logic slot_free;    // output register can take a new result
    } dp_status_t;

    // One byte step of the CRC16-CCITT register.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/cobs_rx_ctrl.sv -----
// ============================================================================
// COBS receiver controller
// State machine that sequences byte collection, the decode walk over the
// raw store, the CRC verdict and the delivery of results.
// ============================================================================
`default_nettype none

module cobs_rx_ctrl
    import cobs_rx_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    input  wire dp_status_t st,
    output ctrl_cmd_t       cmd
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DEC_RD   = 8'b0000_0010,
        S_DEC_PROC = 8'b0000_0100,
        S_DEC_ZERO = 8'b0000_1000,
        S_CHECK    = 8'b0001_0000,
        S_OUT_RD   = 8'b0010_0000,
        S_OUT_LOAD = 8'b0100_0000,
        S_SINGLE   = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                cmd.accept = 1'b1;
                if (s_valid && st.close) begin
                    state_next = S_DEC_RD;
                end
            end
            S_DEC_RD: begin
                state_next = st.dec_stop ? S_CHECK : S_DEC_PROC;
            end
            S_DEC_PROC: begin
                cmd.proc   = 1'b1;
                state_next = st.zero_need ? S_DEC_ZERO : S_DEC_RD;
            end
            S_DEC_ZERO: begin
                cmd.zero   = 1'b1;
                state_next = S_DEC_RD;
            end
            S_CHECK: begin
                if (st.single) begin
                    state_next = S_SINGLE;
                end else begin
                    cmd.out_init = 1'b1;
                    state_next   = S_OUT_RD;
                end
            end
            S_OUT_RD: begin
                state_next = S_OUT_LOAD;
            end
            S_OUT_LOAD: begin
                if (st.slot_free) begin
                    cmd.load_pay = 1'b1;
                    if (st.last_idx) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.out_next = 1'b1;
                        state_next   = S_OUT_RD;
                    end
                end
            end
            S_SINGLE: begin
                if (st.slot_free) begin
                    cmd.load_single = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/cobs_rx_dp.sv -----
// ============================================================================
// COBS receiver datapath
// Raw and decoded byte stores, the COBS unstuffing counters, the running
// CRC with its two-byte hold line, and the output register.
// ============================================================================
`default_nettype none

module cobs_rx_dp
    import cobs_rx_pkg::*;
#(
    parameter int MAX_PAYLOAD = 60,
    parameter int RAW_DEPTH   = 64
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    input  wire logic [7:0]          s_rx_byte,
    input  wire logic                m_ready,
    input  wire ctrl_cmd_t           cmd,
    output dp_status_t               st,
    output logic                     m_valid,
    output logic [STATUS_W-1:0]      m_frame_status,
    output logic [7:0]               m_message_type,
    output logic [LEN_W-1:0]         m_payload_length,
    output logic                     m_has_byte,
    output logic [7:0]               m_payload_value,
    output logic [POS_W-1:0]         m_byte_position,
    output logic                     m_last
);

    localparam int DEC_DEPTH = MAX_PAYLOAD + 3;
    localparam int RAW_AW    = $clog2(RAW_DEPTH);
    localparam int RAW_CW    = $clog2(RAW_DEPTH + 1);
    localparam int DEC_AW    = $clog2(DEC_DEPTH);
    localparam int DEC_CW    = $clog2(DEC_DEPTH + 1);

    // Stores.
    logic [7:0] raw_mem [RAW_DEPTH];
    logic [7:0] dec_mem [DEC_DEPTH];
    logic [7:0] raw_rdata_reg;
    logic [7:0] dec_rdata_reg;

    // Collection state.
    logic              in_frame_reg;
    logic [RAW_CW-1:0] raw_count_reg;
    logic [RAW_CW-1:0] raw_len_reg;

    // Decode state.
    logic [RAW_CW-1:0] rd_reg;
    logic [DEC_CW-1:0] wr_reg;
    logic [7:0]        grp_reg;
    logic              ff_reg;
    logic              err_reg;
    logic [7:0]        type_reg;
    logic [7:0]        h_old_reg;
    logic [7:0]        h_new_reg;
    logic [15:0]       crc_reg;
    logic [DEC_AW-1:0] out_idx_reg;

    // Output register.
    logic                m_valid_reg;
    frame_status_t       status_reg;
    logic [7:0]          type_out_reg;
    logic [LEN_W-1:0]    len_out_reg;
    logic                has_reg;
    logic [7:0]          val_reg;
    logic [POS_W-1:0]    pos_reg;
    logic                last_reg;

    logic              acc;
    logic              byte_zero;
    logic              raw_full;
    logic              emit_en;
    logic [7:0]        emit_val;
    logic              proc_err;
    logic              grp_done;
    logic              ff_eff;
    logic [7:0]        grp_next;
    logic [RAW_CW-1:0] rd_next;
    logic [DEC_CW-1:0] plen;
    logic              dec_bad;
    logic              crc_bad;
    frame_status_t     status_now;
    logic [DEC_AW-1:0] pos_idx;

    assign acc       = cmd.accept && s_valid;
    assign byte_zero = (s_rx_byte == ZERO_BYTE);
    assign raw_full  = (raw_count_reg >= RAW_CW'(RAW_DEPTH));

    // Frame collection: wait for a delimiter, then store bytes up to the next.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg  <= 1'b0;
            raw_count_reg <= '0;
        end else if (acc) begin
            if (!in_frame_reg) begin
                if (byte_zero) begin
                    in_frame_reg  <= 1'b1;
                    raw_count_reg <= '0;
                end
            end else if (!byte_zero) begin
                if (!raw_full) begin
                    raw_count_reg <= raw_count_reg + RAW_CW'(1);
                end else begin
                    in_frame_reg  <= 1'b0;
                    raw_count_reg <= '0;
                end
            end else begin
                raw_count_reg <= '0;
            end
        end
    end

    // Raw store: written while collecting, read at the decode pointer.
    always_ff @(posedge aclk) begin
        if (acc && in_frame_reg && !byte_zero && !raw_full) begin
            raw_mem[raw_count_reg[RAW_AW-1:0]] <= s_rx_byte;
        end
        raw_rdata_reg <= raw_mem[rd_reg[RAW_AW-1:0]];
    end

    assign st.close = in_frame_reg && byte_zero && (raw_count_reg != '0);

    // Unstuffing step: a code byte opens a group, data bytes are copied.
    always_comb begin
        emit_en  = 1'b0;
        emit_val = raw_rdata_reg;
        proc_err = 1'b0;
        grp_done = 1'b0;
        grp_next = grp_reg;
        ff_eff   = ff_reg;
        if (cmd.proc) begin
            if (grp_reg == '0) begin
                ff_eff   = (raw_rdata_reg == FF_BYTE);
                grp_next = raw_rdata_reg - 8'd1;
                if (raw_rdata_reg == ZERO_BYTE) begin
                    proc_err = 1'b1;
                end else begin
                    grp_done = (raw_rdata_reg == ONE_BYTE);
                end
            end else begin
                grp_next = grp_reg - 8'd1;
                if (wr_reg >= DEC_CW'(DEC_DEPTH)) begin
                    proc_err = 1'b1;
                end else begin
                    emit_en  = 1'b1;
                    grp_done = (grp_reg == 8'd1);
                end
            end
        end else if (cmd.zero) begin
            emit_val = ZERO_BYTE;
            if (wr_reg >= DEC_CW'(DEC_DEPTH)) begin
                proc_err = 1'b1;
            end else begin
                emit_en = 1'b1;
            end
        end
    end

    assign rd_next      = rd_reg + RAW_CW'(1);
    assign st.zero_need = grp_done && !ff_eff && (rd_next < raw_len_reg);
    assign st.dec_stop  = err_reg || (rd_reg >= raw_len_reg);

    // Decode counters, CRC over all but the last two decoded bytes.
    always_ff @(posedge aclk) begin
        if (acc && st.close) begin
            raw_len_reg <= raw_count_reg;
            rd_reg      <= '0;
            wr_reg      <= '0;
            grp_reg     <= '0;
            ff_reg      <= 1'b0;
            err_reg     <= 1'b0;
            crc_reg     <= CRC_INIT;
        end else begin
            if (cmd.proc) begin
                rd_reg  <= rd_next;
                grp_reg <= grp_next;
                ff_reg  <= ff_eff;
            end
            if (proc_err) begin
                err_reg <= 1'b1;
            end
            if (emit_en) begin
                wr_reg    <= wr_reg + DEC_CW'(1);
                h_new_reg <= emit_val;
                h_old_reg <= h_new_reg;
                if (wr_reg == '0) begin
                    type_reg <= emit_val;
                end
                if (wr_reg >= DEC_CW'(2)) begin
                    crc_reg <= crc16_byte(crc_reg, h_old_reg);
                end
            end
        end
    end

    // Decoded store: written by the unstuffer, read for payload delivery.
    always_ff @(posedge aclk) begin
        if (emit_en) begin
            dec_mem[wr_reg[DEC_AW-1:0]] <= emit_val;
        end
        dec_rdata_reg <= dec_mem[out_idx_reg];
    end

    // Frame verdict.
    assign plen    = wr_reg - DEC_CW'(3);
    assign dec_bad = err_reg || (grp_reg != '0) || (wr_reg < DEC_CW'(3));
    assign crc_bad = (crc_reg != {h_old_reg, h_new_reg});

    always_comb begin
        if (dec_bad) begin
            status_now = FRAME_DECODE_ERR;
        end else if (crc_bad) begin
            status_now = FRAME_CRC_ERR;
        end else begin
            status_now = FRAME_GOOD;
        end
    end

    assign st.single   = (status_now != FRAME_GOOD) || (plen == '0);
    assign st.last_idx = (DEC_CW'(out_idx_reg) == plen);
    assign st.slot_free = !m_valid_reg || m_ready;

    // Payload read pointer; payload starts after the type byte.
    always_ff @(posedge aclk) begin
        if (cmd.out_init) begin
            out_idx_reg <= DEC_AW'(1);
        end else if (cmd.out_next) begin
            out_idx_reg <= out_idx_reg + DEC_AW'(1);
        end
    end

    assign pos_idx = out_idx_reg - DEC_AW'(1);

    // Output register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_pay || cmd.load_single) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge aclk) begin
        if (cmd.load_single) begin
            status_reg   <= status_now;
            type_out_reg <= (status_now == FRAME_GOOD) ? type_reg : 8'h00;
            len_out_reg  <= '0;
            has_reg      <= 1'b0;
            val_reg      <= 8'h00;
            pos_reg      <= '0;
            last_reg     <= 1'b1;
        end else if (cmd.load_pay) begin
            status_reg   <= FRAME_GOOD;
            type_out_reg <= type_reg;
            len_out_reg  <= LEN_W'(plen);
            has_reg      <= 1'b1;
            val_reg      <= dec_rdata_reg;
            pos_reg      <= POS_W'(pos_idx);
            last_reg     <= st.last_idx;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_frame_status   = status_reg;
    assign m_message_type   = type_out_reg;
    assign m_payload_length = len_out_reg;
    assign m_has_byte       = has_reg;
    assign m_payload_value  = val_reg;
    assign m_byte_position  = pos_reg;
    assign m_last           = last_reg;

endmodule

`default_nettype wire

// ----- rtl/cobs_crc16_frame_receiver_top.sv -----
// ============================================================================
// COBS frame receiver with CRC16-CCITT check
// Top level: controller plus datapath.
// ============================================================================
// Usage:
// The input channel (s_valid, s_ready, s_rx_byte) takes one link byte per
// transaction. Bytes are dropped until the first 0x00; after it, nonzero
// bytes are stored until the next 0x00 closes the frame. A frame that
// overflows the raw store is dropped and the receiver waits for a delimiter.
// While collecting, a byte is taken every cycle. A closing delimiter starts
// the decode walk over the raw store: each stored byte is read from the raw
// store, then unstuffed; each implied zero is appended in a step of its own;
// a last read sees the end, and the CRC verdict follows. s_ready is low
// through that walk and through delivery. A decode error ends the walk early.
// The result channel (m_valid, m_ready, m_*) then gives one transaction per
// payload byte, or a single transaction for an error or an empty payload,
// with m_last on the final one. Each payload result is a read of the decoded
// store followed by a load of the output register.
// When the receiver stalls, the output register holds its result and the
// walk waits. The last result may still wait while new bytes are taken.
// Reset (aresetn low, synchronous) clears the state machine, the
// frame flag, the byte count and the output valid flag.
// ============================================================================
`default_nettype none

module cobs_crc16_frame_receiver_top
    import cobs_rx_pkg::*;
#(
    parameter int MAX_PAYLOAD = 60,
    parameter int RAW_DEPTH   = 64
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [7:0]          s_rx_byte,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [STATUS_W-1:0]      m_frame_status,
    output logic [7:0]               m_message_type,
    output logic [LEN_W-1:0]         m_payload_length,
    output logic                     m_has_byte,
    output logic [7:0]               m_payload_value,
    output logic [POS_W-1:0]         m_byte_position,
    output logic                     m_last
);

    ctrl_cmd_t  cmd;
    dp_status_t st;

    // Sequencer.
    cobs_rx_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .st      (st),
        .cmd     (cmd)
    );

    // Stores, decode and output register.
    cobs_rx_dp #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .RAW_DEPTH   (RAW_DEPTH)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_rx_byte        (s_rx_byte),
        .m_ready          (m_ready),
        .cmd              (cmd),
        .st               (st),
        .m_valid          (m_valid),
        .m_frame_status   (m_frame_status),
        .m_message_type   (m_message_type),
        .m_payload_length (m_payload_length),
        .m_has_byte       (m_has_byte),
        .m_payload_value  (m_payload_value),
        .m_byte_position  (m_byte_position),
        .m_last           (m_last)
    );

    assign s_ready = cmd.accept;

endmodule

`default_nettype wire

// ----- rtl/cobs_rx_checker.sv -----
// ============================================================================
// COBS receiver port checker
// Assertions on the top level's ports, attached by a bind statement.
// ============================================================================
`default_nettype none

module cobs_rx_checker
    import cobs_rx_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire logic [7:0]          s_rx_byte,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire logic [STATUS_W-1:0] m_frame_status,
    input wire logic [7:0]          m_message_type,
    input wire logic [LEN_W-1:0]    m_payload_length,
    input wire logic                m_has_byte,
    input wire logic [7:0]          m_payload_value,
    input wire logic [POS_W-1:0]    m_byte_position,
    input wire logic                m_last
);

    // A stalled result stays offered.
    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_payload_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_payload_value) && $stable(m_last)
            && $stable(m_byte_position) && $stable(m_frame_status))
        else $error("result changed while stalled");

    // An error result is a lone, empty, final transaction.
    a_error_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_frame_status != FRAME_GOOD) |-> m_last && !m_has_byte
            && (m_message_type == 8'h00) && (m_payload_length == '0))
        else $error("malformed error result");

    // A result without a payload byte ends its frame and carries zeros.
    a_empty_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_has_byte |-> m_last && (m_payload_value == 8'h00)
            && (m_byte_position == '0))
        else $error("malformed result without payload byte");

    // A payload byte lies inside the announced payload.
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_has_byte |-> (m_byte_position < m_payload_length))
        else $error("payload position beyond payload length");

endmodule

bind cobs_crc16_frame_receiver_top cobs_rx_checker u_cobs_rx_checker (.*);

`default_nettype wire
